// ===== sv/qsfs_pkg.sv =====
// Package: shared types and codes of the query string field splitter.
package qsfs_pkg;

  localparam int unsigned MAX_FIELDS_DEF = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  localparam logic [1:0] VER_ACCEPTED = 2'd0;
  localparam logic [1:0] VER_NO_EQ    = 2'd1;
  localparam logic [1:0] VER_EMPTY    = 2'd2;

  localparam logic [1:0] END_OK       = 2'd0;
  localparam logic [1:0] END_NO_QUERY = 2'd1;
  localparam logic [1:0] END_EMPTY    = 2'd2;
  localparam logic [1:0] END_LIMIT    = 2'd3;

  localparam logic [4:0] ACC_MAX = 5'd31;

  typedef enum logic [1:0] {
    PH_ROUTE = 2'd0,
    PH_QUERY = 2'd1,
    PH_STOP  = 2'd2,
    PH_LIMIT = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic [1:0] code;
    logic [3:0] pair_index;
    logic [4:0] accepted_count;
    logic       last_of_run;
  } res_t;

endpackage

// ===== sv/qsfs_if.sv =====
// Interfaces: URI byte input channel and parse result channel.
interface qsfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] uri_byte;
  logic       is_last;

  modport source (output valid, output uri_byte, output is_last, input ready);
  modport sink   (input valid, input uri_byte, input is_last, output ready);
endinterface

interface qsfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] code;
  logic [3:0] pair_index;
  logic [4:0] accepted_count;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output code,
                  output pair_index, output accepted_count, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input code,
                  input pair_index, input accepted_count, input last_of_run,
                  output ready);
endinterface

// ===== sv/query_string_field_splitter_core.sv =====
// Top level: streaming URI query string splitter.
//
// in_ch takes one URI byte per transfer, with is_last on the final byte.
// out_ch gives name/value bytes, pair verdicts and one end result per URI;
// last_of_run marks the final result caused by an input byte.
// Each input byte causes zero to three results. They are formed in the
// cycle of the input transfer and held in a three-entry result buffer,
// so the first result is valid in the cycle after its byte is taken.
// Throughput is one byte per cycle while each byte causes at most one
// result and out_ch.ready is high; several results of one byte share the
// single result port in turn, and in_ch.ready drops until the last entry leaves.
// Parse state is updated at the input transfer; after the last byte it
// returns to its reset values for the next URI.
// Reset (rst_n low, synchronous) empties the buffer and clears the state.
// When out_ch.ready is low, results hold and in_ch stalls while any
// result is still waiting in the buffer.
module query_string_field_splitter_core
  import qsfs_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  qsfs_in_if.sink      in_ch,
  qsfs_out_if.source   out_ch
);

  localparam int unsigned PW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam logic [PW-1:0] PAIR_LAST = PW'(MAX_FIELDS - 1);

  phase_t        phase_r, phase_nxt;
  logic          in_value_r, in_value_nxt;
  logic          value_seen_r, value_seen_nxt;
  logic [PW-1:0] pair_r, pair_nxt;
  logic [4:0]    acc_r, acc_nxt;

  res_t       buf_r [3];
  logic [1:0] cnt_r;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic       is_amp, is_eq_open, is_data;
  logic       in_value_eff, value_seen_eff;
  logic [1:0] ver_code;
  logic [4:0] acc_ver;
  phase_t     phase_ver;
  logic       pb, pv, pe;
  res_t       r_byte, r_ver, r_end;
  res_t       res [3];
  logic [1:0] n_res;
  logic [3:0] pair_out;
  logic [PW+3:0] pair_ext;

  assign b       = in_ch.uri_byte;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  assign pair_ext = {4'b0, pair_r};
  assign pair_out = pair_ext[3:0];

  // decode of the current byte against the parse state
  always_comb begin
    is_amp         = (b == CH_AMP);
    is_eq_open     = (b == CH_EQ) && !in_value_r;
    is_data        = !is_amp && !is_eq_open;
    in_value_eff   = in_value_r || is_eq_open;
    value_seen_eff = value_seen_r || (is_data && in_value_r);
    if (!in_value_eff) begin
      ver_code = VER_NO_EQ;
    end else if (!value_seen_eff) begin
      ver_code = VER_EMPTY;
    end else begin
      ver_code = VER_ACCEPTED;
    end
    acc_ver = acc_r;
    if ((ver_code == VER_ACCEPTED) && (acc_r != ACC_MAX)) begin
      acc_ver = acc_r + 5'd1;
    end
    phase_ver = (ver_code == VER_EMPTY) ? PH_STOP : PH_QUERY;
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    in_value_nxt   = in_value_r;
    value_seen_nxt = value_seen_r;
    pair_nxt       = pair_r;
    acc_nxt        = acc_r;
    case (phase_r)
      PH_ROUTE: begin
        if (b == CH_QMARK) begin
          phase_nxt = PH_QUERY;
        end
      end
      PH_QUERY: begin
        in_value_nxt   = in_value_eff;
        value_seen_nxt = value_seen_eff;
        if (is_amp || in_ch.is_last) begin
          phase_nxt = phase_ver;
          acc_nxt   = acc_ver;
        end
        if (is_amp && !in_ch.is_last && (phase_ver == PH_QUERY)) begin
          if (pair_r == PAIR_LAST) begin
            phase_nxt = PH_LIMIT;
          end else begin
            pair_nxt       = pair_r + PW'(1);
            in_value_nxt   = 1'b0;
            value_seen_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    if (in_ch.is_last) begin
      phase_nxt      = PH_ROUTE;
      in_value_nxt   = 1'b0;
      value_seen_nxt = 1'b0;
      pair_nxt       = '0;
      acc_nxt        = '0;
    end
  end

  // results caused by the current byte
  always_comb begin
    pb = 1'b0;
    pv = 1'b0;
    pe = in_ch.is_last;

    r_byte                = '0;
    r_byte.kind           = in_value_r ? KIND_VALUE : KIND_NAME;
    r_byte.out_byte       = (b == CH_PLUS) ? CH_SPACE : b;
    r_byte.pair_index     = pair_out;
    r_byte.accepted_count = acc_r;

    r_ver                = '0;
    r_ver.kind           = KIND_VERDICT;
    r_ver.code           = ver_code;
    r_ver.pair_index     = pair_out;
    r_ver.accepted_count = acc_ver;

    r_end                = '0;
    r_end.kind           = KIND_END;
    r_end.pair_index     = pair_out;
    r_end.accepted_count = acc_r;
    r_end.last_of_run    = 1'b1;

    case (phase_r)
      PH_ROUTE: begin
        r_end.code = (b == CH_QMARK) ? END_EMPTY : END_NO_QUERY;
      end
      PH_QUERY: begin
        pb = is_data;
        pv = is_amp || in_ch.is_last;
        r_end.accepted_count = acc_ver;
        r_end.code           = END_OK;
      end
      PH_LIMIT: begin
        r_end.code = END_LIMIT;
      end
      default: begin
        r_end.code = END_OK;
      end
    endcase

    r_byte.last_of_run = !pv && !pe;
    r_ver.last_of_run  = !pe;

    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    if (pe) begin
      res[2'({1'b0, pb}) + 2'({1'b0, pv})] = r_end;
    end
    if (pv) begin
      res[2'({1'b0, pb})] = r_ver;
    end
    if (pb) begin
      res[0] = r_byte;
    end
    n_res = 2'({1'b0, pb}) + 2'({1'b0, pv}) + 2'({1'b0, pe});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ROUTE;
      in_value_r   <= 1'b0;
      value_seen_r <= 1'b0;
      pair_r       <= '0;
      acc_r        <= '0;
      cnt_r        <= 2'd0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        in_value_r   <= in_value_nxt;
        value_seen_r <= value_seen_nxt;
        pair_r       <= pair_nxt;
        acc_r        <= acc_nxt;
        cnt_r        <= n_res;
      end else if (out_fire) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r[0] <= res[0];
      buf_r[1] <= res[1];
      buf_r[2] <= res[2];
    end else if (out_fire) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.kind           = buf_r[0].kind;
  assign out_ch.out_byte       = buf_r[0].out_byte;
  assign out_ch.code           = buf_r[0].code;
  assign out_ch.pair_index     = buf_r[0].pair_index;
  assign out_ch.accepted_count = buf_r[0].accepted_count;
  assign out_ch.last_of_run    = buf_r[0].last_of_run;

endmodule

// ===== bench/tb.sv =====
// Testbench: query_string_field_splitter_core, directed table plus random URIs vs. predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qsfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0]  CODE_NONE   = 2'd0;

  localparam int STYLE_NOISE    = 0;
  localparam int STYLE_NO_QUERY = 1;
  localparam int STYLE_LONG     = 2;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       typed;
    res_t       want;
    logic       hold;
  } row_t;

  logic clk;
  logic rst_n;

  qsfs_in_if  in_if ();
  qsfs_out_if out_if ();

  query_string_field_splitter_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state
  phase_t      parse_phase;
  logic        in_val;
  logic        val_seen;
  int unsigned pair_no;
  int unsigned acc_fields;

  res_t        byte_results[$];
  res_t        pending_results[$];
  row_t        plan[$];
  logic [7:0]  uri_bytes[$];

  int idle_pct;
  int stall_pct;
  int mismatches;
  int results_checked;
  int limit_ends;
  int total_bytes;
  int total_uris;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_parse();
    parse_phase = PH_ROUTE;
    in_val      = 1'b0;
    val_seen    = 1'b0;
    pair_no     = 0;
    acc_fields  = 0;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] b, logic [1:0] c);
    res_t r;
    r.kind           = k;
    r.out_byte       = b;
    r.code           = c;
    r.pair_index     = pair_no[3:0];
    r.accepted_count = (acc_fields > 31) ? ACC_MAX : 5'(acc_fields);
    r.last_of_run    = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void close_pair();
    if (!in_val) begin
      emit(KIND_VERDICT, 8'h00, VER_NO_EQ);
    end else if (!val_seen) begin
      parse_phase = PH_STOP;
      emit(KIND_VERDICT, 8'h00, VER_EMPTY);
    end else begin
      acc_fields++;
      emit(KIND_VERDICT, 8'h00, VER_ACCEPTED);
    end
  endfunction

  function automatic logic [1:0] end_code();
    return (parse_phase == PH_LIMIT) ? END_LIMIT : END_OK;
  endfunction

  // results caused by one URI byte, left in byte_results
  function automatic void split_byte(logic [7:0] b, logic last);
    logic [7:0] c;
    byte_results.delete();
    case (parse_phase)
      PH_ROUTE: begin
        if (b == CH_QMARK) begin
          parse_phase = PH_QUERY;
          if (last) emit(KIND_END, 8'h00, END_EMPTY);
        end else if (last) begin
          emit(KIND_END, 8'h00, END_NO_QUERY);
        end
      end
      PH_QUERY: begin
        if (b == CH_AMP) begin
          close_pair();
          if (!last && parse_phase == PH_QUERY) begin
            if (pair_no + 1 >= MAX_FIELDS_DEF) begin
              parse_phase = PH_LIMIT;
            end else begin
              pair_no++;
              in_val   = 1'b0;
              val_seen = 1'b0;
            end
          end
        end else if (b == CH_EQ && !in_val) begin
          in_val = 1'b1;
          if (last) close_pair();
        end else begin
          c = (b == CH_PLUS) ? CH_SPACE : b;
          if (in_val) begin
            val_seen = 1'b1;
            emit(KIND_VALUE, c, CODE_NONE);
          end else begin
            emit(KIND_NAME, c, CODE_NONE);
          end
          if (last) close_pair();
        end
        if (last) emit(KIND_END, 8'h00, end_code());
      end
      default: begin
        if (last) emit(KIND_END, 8'h00, end_code());
      end
    endcase
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].last_of_run = 1'b1;
    if (last) clear_parse();
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic last = 1'b0,
                                  input logic typed = 1'b0, input res_t want = '0,
                                  input logic hold = 1'b0);
    row_t r;
    r.b     = b;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    r.hold  = hold;
    plan.push_back(r);
  endfunction

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return letter();
    if (sel < 14) return CH_PLUS;
    if (sel == 14) return CH_EQ;
    if (sel == 15) return CH_QMARK;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void make_uri(int style);
    int  pairs;
    int  len;
    logic is_long;
    uri_bytes.delete();
    if (style == STYLE_NOISE) begin
      len = $urandom_range(1, 6);
      repeat (len) uri_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    is_long = (style == STYLE_LONG);
    repeat ($urandom_range(0, 3))
      uri_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h2F : letter());
    if (style != STYLE_NO_QUERY) uri_bytes.push_back(CH_QMARK);
    pairs = is_long ? $urandom_range(16, 17) : $urandom_range(0, 4);
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) begin
        uri_bytes.push_back(CH_AMP);
        if (!is_long && $urandom_range(0, 15) == 0) uri_bytes.push_back(CH_AMP);
      end
      if (is_long) begin
        uri_bytes.push_back(letter());
        uri_bytes.push_back(CH_EQ);
        uri_bytes.push_back(letter());
      end else begin
        repeat ($urandom_range(0, 3)) uri_bytes.push_back(pick_char());
        if ($urandom_range(0, 7) != 0) begin
          uri_bytes.push_back(CH_EQ);
          len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
          repeat (len) uri_bytes.push_back(pick_char());
        end
      end
    end
    if ($urandom_range(0, 5) == 0) uri_bytes.push_back(CH_AMP);
    if (uri_bytes.size() == 0) uri_bytes.push_back(pick_char());
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed = 1'b0, input res_t want = '0);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.uri_byte <= b;
    in_if.is_last  <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    split_byte(b, last);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (byte_results[k]) pending_results.push_back(byte_results[k]);
    end
    total_bytes++;
    if (last) total_uris++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind           = kind_t'(out_if.kind);
      got.out_byte       = out_if.out_byte;
      got.code           = out_if.code;
      got.pair_index     = out_if.pair_index;
      got.accepted_count = out_if.accepted_count;
      got.last_of_run    = out_if.last_of_run;
      if (got.kind == KIND_END && got.code == END_LIMIT) limit_ends++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d byte %h code %0d", got.kind, got.out_byte,
                   got.code);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.code !== want.code || got.pair_index !== want.pair_index ||
            got.accepted_count !== want.accepted_count ||
            got.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d (exp/got): kind %0d/%0d byte %h/%h",
                     results_checked, want.kind, got.kind, want.out_byte, got.out_byte,
                     " code %0d/%0d pair %0d/%0d acc %0d/%0d last %0b/%0b",
                     want.code, got.code, want.pair_index, got.pair_index,
                     want.accepted_count, got.accepted_count, want.last_of_run,
                     got.last_of_run);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("query_string_field_splitter_core test failed");
    $finish;
  end

  initial begin
    int phase_bytes;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.uri_byte  = 8'h00;
    in_if.is_last   = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    mismatches      = 0;
    results_checked = 0;
    limit_ends      = 0;
    total_bytes     = 0;
    total_uris      = 0;
    clear_parse();

    // no query at all, then a bare '?'
    add_row(8'h78, 1'b1, 1'b1, '{KIND_END, 8'h00, END_NO_QUERY, 4'd0, 5'd0, 1'b1});
    add_row(CH_QMARK, 1'b1, 1'b1, '{KIND_END, 8'h00, END_EMPTY, 4'd0, 5'd0, 1'b1});
    // plus as space, extra '=' in value, empty pair, '?' in value, zero byte, trailing '&'
    add_row(CH_QMARK);
    add_row(CH_PLUS);
    add_row(CH_EQ);
    add_row(8'hFF, 1'b0, 1'b1, '{KIND_VALUE, 8'hFF, CODE_NONE, 4'd0, 5'd0, 1'b1});
    add_row(CH_EQ);
    add_row(CH_AMP, 1'b0, 1'b0, '0, 1'b1);
    add_row(CH_AMP);
    add_row(CH_EQ);
    add_row(CH_QMARK);
    add_row(CH_AMP);
    add_row(8'h00);
    add_row(CH_AMP, 1'b1);
    // empty value stops parsing
    add_row(CH_QMARK);
    add_row(8'h61);
    add_row(CH_EQ);
    add_row(CH_AMP);
    add_row(8'h63, 1'b1);
    // empty name, three results on one byte
    add_row(CH_QMARK);
    add_row(CH_EQ);
    add_row(8'h76, 1'b1);
    // empty value on the last byte
    add_row(CH_QMARK);
    add_row(8'h6B);
    add_row(CH_EQ, 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].hold) wait_drained();
      send_byte(plan[k].b, plan[k].last, plan[k].typed, plan[k].want);
    end
    wait_drained();

    for (int pn = 0; pn < 4; pn++) begin
      case (pn)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 30) begin
        make_uri((pn == 1 && phase_bytes == 0) ? STYLE_LONG : $urandom_range(0, 19));
        foreach (uri_bytes[k]) send_byte(uri_bytes[k], k == uri_bytes.size() - 1);
        phase_bytes += uri_bytes.size();
      end
      wait_drained();
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d URIs, %0d bytes, %0d results checked (%0d field-limit ends)",
             total_uris, total_bytes, results_checked, limit_ends);
    $display("four idle/stall patterns on both channels; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("query_string_field_splitter_core test passed");
    end else begin
      $display("query_string_field_splitter_core test failed");
    end
    $finish;
  end

endmodule
